/* hdl/lrg_pkg.sv */
// Package with item types and codes shared by the linear ramp generator modules.
package lrg_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned StepsW = 8;
  localparam int unsigned DiffW  = ValueW + 1;

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeSet    = 2'd1,
    ModeTarget = 2'd2
  } lrg_mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StHold
  } lrg_state_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [ValueW-1:0] value;
    logic [StepsW-1:0]        steps;
  } lrg_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] current;
    logic                     done_res;
  } lrg_out_t;

endpackage

/* hdl/lrg_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
module lrg_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lrg_pkg::DiffW-1:0]        dividend_i,
  input  logic [lrg_pkg::StepsW-1:0]       divisor_i,
  output logic                             done_o,
  output logic [lrg_pkg::DiffW-1:0]        quotient_o
);

  localparam int unsigned CntW = $clog2(lrg_pkg::DiffW + 1);

  logic [lrg_pkg::DiffW-1:0]  dq_q, dq_d;
  logic [lrg_pkg::StepsW-1:0] rem_q, rem_d;
  logic [lrg_pkg::StepsW-1:0] dvs_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [lrg_pkg::StepsW:0]   trial;
  logic [lrg_pkg::StepsW+1:0] diff;
  logic                       ge;

  // shift next dividend bit into the partial remainder, try subtracting
  assign trial = {rem_q, dq_q[lrg_pkg::DiffW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[lrg_pkg::StepsW+1];

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(lrg_pkg::DiffW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dq_d  = {dq_q[lrg_pkg::DiffW-2:0], ge};
      rem_d = ge ? diff[lrg_pkg::StepsW-1:0] : trial[lrg_pkg::StepsW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

/* hdl/linear_ramp_generator.sv */
// Linear ramp generator top level: item handling, ramp state and output register.
// Tick and set-value items go straight into the output register, one item per cycle
// while the output is not stalled. Set-target with a nonzero step count: the step size
// comes from the bit-serial divider (17 quotient bits), then step and result are loaded.
// No further item is taken until that result is registered and the ramp is idle again.
// Reset (rst_ni low, asynchronous) clears value, target, step size and counters.
module linear_ramp_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lrg_pkg::lrg_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lrg_pkg::lrg_out_t out_o
);

  localparam int unsigned VW = lrg_pkg::ValueW;
  localparam int unsigned SW = lrg_pkg::StepsW;
  localparam int unsigned DW = lrg_pkg::DiffW;

  lrg_pkg::lrg_state_e state_q, state_d;

  logic signed [VW-1:0] cur_q, cur_d;
  logic signed [VW-1:0] tgt_q, tgt_d;
  logic signed [DW-1:0] step_q, step_d;
  logic [SW-1:0]        taken_q, taken_d;
  logic [SW-1:0]        total_q, total_d;
  logic                 neg_q;

  logic                 out_valid_q;
  lrg_pkg::lrg_out_t    out_q;

  logic                 accept;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic                 load_hold;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_mag;
  logic [DW-1:0]        quot;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != lrg_pkg::StIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign diff     = DW'(in_i.value) - DW'(cur_q);
  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrg_pkg::StIdle: begin
        if (div_start) begin
          state_d = lrg_pkg::StDiv;
        end
      end
      lrg_pkg::StDiv: begin
        if (div_done) begin
          state_d = lrg_pkg::StHold;
        end
      end
      lrg_pkg::StHold: begin
        if (out_free) begin
          state_d = lrg_pkg::StIdle;
        end
      end
      default: state_d = lrg_pkg::StIdle;
    endcase
  end

  // state machine outputs
  always_comb begin
    div_start = 1'b0;
    load_hold = 1'b0;
    unique case (state_q)
      lrg_pkg::StIdle: begin
        div_start = accept && (in_i.mode == lrg_pkg::ModeTarget) && (in_i.steps != '0);
      end
      lrg_pkg::StDiv: ;
      lrg_pkg::StHold: begin
        load_hold = out_free;
      end
      default: ;
    endcase
  end

  // ramp state update
  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    step_d  = step_q;
    taken_d = taken_q;
    total_d = total_q;
    if (accept) begin
      case (in_i.mode)
        lrg_pkg::ModeTick: begin
          if (taken_q >= total_q) begin
            cur_d = tgt_q;
          end else begin
            cur_d   = cur_q + step_q[VW-1:0];
            taken_d = taken_q + SW'(1);
          end
        end
        lrg_pkg::ModeSet: begin
          cur_d   = in_i.value;
          tgt_d   = in_i.value;
          step_d  = '0;
          taken_d = '0;
          total_d = '0;
        end
        lrg_pkg::ModeTarget: begin
          tgt_d   = in_i.value;
          taken_d = '0;
          total_d = in_i.steps;
          if (in_i.steps == '0) begin
            step_d = '0;
          end
        end
        default: ;  // unused code: no change
      endcase
    end
    if (div_done) begin
      step_d = neg_q ? DW'(-quot) : DW'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrg_pkg::StIdle;
      cur_q       <= '0;
      tgt_q       <= '0;
      step_q      <= '0;
      taken_q     <= '0;
      total_q     <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
      step_q  <= step_d;
      taken_q <= taken_d;
      total_q <= total_d;
      if (div_start) begin
        neg_q <= diff[DW-1];
      end
      if ((accept && !div_start) || load_hold) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((accept && !div_start) || load_hold) begin
      out_q.current  <= cur_d;
      out_q.done_res <= (taken_d >= total_d);
    end
  end

  lrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_mag),
    .divisor_i  (in_i.steps),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // a ramp never counts past its own length
  assert property (@(posedge clk_i) disable iff (!rst_ni) taken_q <= total_q)
    else $error("steps taken exceeds step count");

  // the divider reports back only while the ramp waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == lrg_pkg::StDiv)
    else $error("divider done outside divide state");

  // no item enters and no result waits at the output while a step size is being worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lrg_pkg::StDiv |-> in_stall_o && !out_valid_q)
    else $error("input open or result pending during divide");

endmodule
